[design/motor_command_line_decoder_macros.svh]
// Assertion macros used by the motor command line decoder checker.
`ifndef MOTOR_COMMAND_LINE_DECODER_MACROS_SVH
`define MOTOR_COMMAND_LINE_DECODER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define MCLD_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition required in the cycle after the antecedent.
`define MCLD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/mcld_pkg.sv]
// Types and constants of the motor command line decoder.
`default_nettype none

package mcld_pkg;

   // Parse phases of one command line
   typedef enum logic [2:0] {
      PH_COLON  = 3'd0,
      PH_LETTER = 3'd1,
      PH_LSIGN  = 3'd2,
      PH_LDIG   = 3'd3,
      PH_RSIGN  = 3'd4,
      PH_RDIG   = 3'd5,
      PH_FDIG   = 3'd6,
      PH_NL     = 3'd7
   } phase_type;

   // Result kinds
   localparam logic [2:0] KIND_SPEED   = 3'd0;
   localparam logic [2:0] KIND_FREQ    = 3'd1;
   localparam logic [2:0] KIND_HEADING = 3'd2;
   localparam logic [2:0] KIND_CALIB   = 3'd3;
   localparam logic [2:0] KIND_ERROR   = 3'd4;

   // Error codes; ERR_NONE marks no error found yet
   localparam logic [1:0] ERR_COLON   = 2'd0;
   localparam logic [1:0] ERR_UNKNOWN = 2'd1;
   localparam logic [1:0] ERR_SYNTAX  = 2'd2;
   localparam logic [1:0] ERR_NONE    = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] REG_SPEED   = 2'd0;
   localparam logic [1:0] REG_FREQ    = 2'd1;
   localparam logic [1:0] REG_HEADING = 2'd2;
   localparam logic [1:0] REG_CALIB   = 2'd3;

   // Characters
   localparam logic [7:0] CHR_COLON   = 8'h3A;
   localparam logic [7:0] CHR_MINUS   = 8'h2D;
   localparam logic [7:0] CHR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHR_ZERO    = 8'd48;
   localparam logic [7:0] CHR_NINE    = 8'd57;

   // Field counts
   localparam logic [2:0] SPEED_DIGITS = 3'd3;
   localparam logic [2:0] FREQ_DIGITS  = 3'd5;

   // Result packing
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 3;

   typedef struct packed {
      logic [7:0] speed;
      logic [7:0] freq;
      logic [7:0] heading;
      logic [7:0] calib;
   } letters_type;

   typedef struct packed {
      logic [2:0]         cmd_kind;
      logic signed [10:0] left_speed;
      logic signed [10:0] right_speed;
      logic [16:0]        pwm_freq;
      logic [1:0]         error_code;
   } result_type;

endpackage

`default_nettype wire

[design/motor_command_line_decoder.sv]
// A line's last byte passes from the input register through the parse stage into the
// result register, which drives rsp.
// Throughput: one byte per cycle unless a stalled result holds the parse stage.
// A stalled result holds the parse stage; the input register then fills and tready drops.
// Reset (synchronous, active high) clears the parse state and both valid flags and
// loads the letter registers with 'S', 'F', 'H' and 'C'.
`default_nettype none

module motor_command_line_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte stream in
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tlast,   // line_end
   // decoded commands out
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [mcld_pkg::RSP_DATA_W-1:0] rsp_tdata,
      // [10:0] left_speed, [21:11] right_speed, [38:22] pwm_freq,
      // [40:39] error_code, [47:41] zero
   output logic [mcld_pkg::RSP_USER_W-1:0] rsp_tuser,  // [2:0] cmd_kind
   // letter registers
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [7:0]  csr_wdata
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_last_ff, in_last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   mcld_pkg::result_type rsp_ff, rsp_in, result;
   mcld_pkg::letters_type letters_ff, letters_in;
   logic        out_free;
   logic        step;

   // The parse stage consumes a valid item unless it ends a line and a stalled result fills the slot
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || step;

   mcld_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .rx_byte  (in_byte_ff),
      .line_end (in_last_ff),
      .letters  (letters_ff),
      .result   (result)
   );

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (step && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Letter registers
   always_comb begin
      letters_in = letters_ff;
      if (csr_we) begin
         unique case (csr_addr)
            mcld_pkg::REG_SPEED:   letters_in.speed   = csr_wdata;
            mcld_pkg::REG_FREQ:    letters_in.freq    = csr_wdata;
            mcld_pkg::REG_HEADING: letters_in.heading = csr_wdata;
            mcld_pkg::REG_CALIB:   letters_in.calib   = csr_wdata;
            default:               letters_in = letters_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         letters_ff   <= '{speed: 8'd83, freq: 8'd70, heading: 8'd72, calib: 8'd67};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         letters_ff   <= letters_in;
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.cmd_kind;
   assign rsp_tdata  = {7'd0, rsp_ff.error_code, rsp_ff.pwm_freq,
                        rsp_ff.right_speed, rsp_ff.left_speed};

endmodule

`default_nettype wire

[design/mcld_parse.sv]
// Command line parser: parse state registers and the per-byte step logic.
`default_nettype none

module mcld_parse (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,       // one item consumed this cycle
   input  wire logic [7:0]           rx_byte,
   input  wire logic                 line_end,
   input  wire mcld_pkg::letters_type letters,
   output mcld_pkg::result_type      result      // valid when step && line_end
);

   mcld_pkg::phase_type phase_ff, phase_in, phase_n;
   logic [2:0]  pos_ff, pos_in, pos_n, pos_inc;
   logic [1:0]  cmd_ff, cmd_in, cmd_n;
   logic        neg1_ff, neg1_in, neg1_n;
   logic        neg2_ff, neg2_in, neg2_n;
   logic [16:0] val1_ff, val1_in, val1_n;
   logic [9:0]  val2_ff, val2_in, val2_n;
   logic [1:0]  err_ff, err_in, err_n;
   logic        done_ff, done_in, done_n;

   logic        is_digit;
   logic [3:0]  digit;
   logic [16:0] val1_mac;
   logic [9:0]  val2_mac;

   assign is_digit = (rx_byte >= mcld_pkg::CHR_ZERO) && (rx_byte <= mcld_pkg::CHR_NINE);
   assign digit    = 4'(rx_byte - mcld_pkg::CHR_ZERO);
   // times ten plus digit, as two shifts and adds
   assign val1_mac = (val1_ff << 3) + (val1_ff << 1) + 17'(digit);
   assign val2_mac = (val2_ff << 3) + (val2_ff << 1) + 10'(digit);
   assign pos_inc  = pos_ff + 3'd1;

   // State after taking this byte
   always_comb begin
      phase_n = phase_ff;
      pos_n   = pos_ff;
      cmd_n   = cmd_ff;
      neg1_n  = neg1_ff;
      neg2_n  = neg2_ff;
      val1_n  = val1_ff;
      val2_n  = val2_ff;
      err_n   = err_ff;
      done_n  = done_ff;
      if (!done_ff && err_ff == mcld_pkg::ERR_NONE) begin
         unique case (phase_ff)
            mcld_pkg::PH_COLON: begin
               if (rx_byte == mcld_pkg::CHR_COLON) phase_n = mcld_pkg::PH_LETTER;
               else err_n = mcld_pkg::ERR_COLON;
            end
            mcld_pkg::PH_LETTER: begin
               // first matching letter wins
               if (rx_byte == letters.speed) begin
                  cmd_n   = 2'(mcld_pkg::KIND_SPEED);
                  phase_n = mcld_pkg::PH_LSIGN;
               end else if (rx_byte == letters.freq) begin
                  cmd_n   = 2'(mcld_pkg::KIND_FREQ);
                  phase_n = mcld_pkg::PH_FDIG;
                  pos_n   = 3'd0;
               end else if (rx_byte == letters.heading) begin
                  cmd_n   = 2'(mcld_pkg::KIND_HEADING);
                  phase_n = mcld_pkg::PH_NL;
               end else if (rx_byte == letters.calib) begin
                  cmd_n   = 2'(mcld_pkg::KIND_CALIB);
                  phase_n = mcld_pkg::PH_NL;
               end else begin
                  err_n = mcld_pkg::ERR_UNKNOWN;
               end
            end
            mcld_pkg::PH_LSIGN: begin
               if (rx_byte == mcld_pkg::CHR_MINUS) begin
                  neg1_n  = 1'b1;
                  pos_n   = 3'd0;
                  phase_n = mcld_pkg::PH_LDIG;
               end else if (is_digit) begin
                  val1_n  = 17'(digit);
                  pos_n   = 3'd1;
                  phase_n = mcld_pkg::PH_LDIG;
               end else begin
                  err_n = mcld_pkg::ERR_SYNTAX;
               end
            end
            mcld_pkg::PH_RSIGN: begin
               if (rx_byte == mcld_pkg::CHR_MINUS) begin
                  neg2_n  = 1'b1;
                  pos_n   = 3'd0;
                  phase_n = mcld_pkg::PH_RDIG;
               end else if (is_digit) begin
                  val2_n  = 10'(digit);
                  pos_n   = 3'd1;
                  phase_n = mcld_pkg::PH_RDIG;
               end else begin
                  err_n = mcld_pkg::ERR_SYNTAX;
               end
            end
            mcld_pkg::PH_LDIG: begin
               if (!is_digit) begin
                  err_n = mcld_pkg::ERR_SYNTAX;
               end else begin
                  val1_n = val1_mac;
                  pos_n  = pos_inc;
                  if (pos_inc >= mcld_pkg::SPEED_DIGITS) begin
                     pos_n   = 3'd0;
                     phase_n = mcld_pkg::PH_RSIGN;
                  end
               end
            end
            mcld_pkg::PH_RDIG: begin
               if (!is_digit) begin
                  err_n = mcld_pkg::ERR_SYNTAX;
               end else begin
                  val2_n = val2_mac;
                  pos_n  = pos_inc;
                  if (pos_inc >= mcld_pkg::SPEED_DIGITS) begin
                     pos_n   = 3'd0;
                     phase_n = mcld_pkg::PH_NL;
                  end
               end
            end
            mcld_pkg::PH_FDIG: begin
               if (!is_digit) begin
                  err_n = mcld_pkg::ERR_SYNTAX;
               end else begin
                  val1_n = val1_mac;
                  pos_n  = pos_inc;
                  if (pos_inc >= mcld_pkg::FREQ_DIGITS) begin
                     pos_n   = 3'd0;
                     phase_n = mcld_pkg::PH_NL;
                  end
               end
            end
            mcld_pkg::PH_NL: begin
               if (rx_byte == mcld_pkg::CHR_NEWLINE) done_n = 1'b1;
               else err_n = mcld_pkg::ERR_SYNTAX;
            end
            default: err_n = mcld_pkg::ERR_SYNTAX;
         endcase
      end
   end

   // Result of the line ending with this byte
   always_comb begin
      result = '0;
      if (done_n) begin
         result.cmd_kind = 3'(cmd_n);
         if (3'(cmd_n) == mcld_pkg::KIND_SPEED) begin
            result.left_speed  = neg1_n ? (11'sd0 - $signed(val1_n[10:0]))
                                        : $signed(val1_n[10:0]);
            result.right_speed = neg2_n ? (11'sd0 - $signed({1'b0, val2_n}))
                                        : $signed({1'b0, val2_n});
         end else if (3'(cmd_n) == mcld_pkg::KIND_FREQ) begin
            result.pwm_freq = val1_n;
         end
      end else begin
         result.cmd_kind = mcld_pkg::KIND_ERROR;
         if (err_n != mcld_pkg::ERR_NONE) result.error_code = err_n;
         else if (phase_n == mcld_pkg::PH_LETTER) result.error_code = mcld_pkg::ERR_UNKNOWN;
         else result.error_code = mcld_pkg::ERR_SYNTAX;
      end
   end

   // Advance on each byte; the last byte of a line clears everything
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      cmd_in   = cmd_ff;
      neg1_in  = neg1_ff;
      neg2_in  = neg2_ff;
      val1_in  = val1_ff;
      val2_in  = val2_ff;
      err_in   = err_ff;
      done_in  = done_ff;
      if (step) begin
         if (line_end) begin
            phase_in = mcld_pkg::PH_COLON;
            pos_in   = 3'd0;
            cmd_in   = 2'd0;
            neg1_in  = 1'b0;
            neg2_in  = 1'b0;
            val1_in  = 17'd0;
            val2_in  = 10'd0;
            err_in   = mcld_pkg::ERR_NONE;
            done_in  = 1'b0;
         end else begin
            phase_in = phase_n;
            pos_in   = pos_n;
            cmd_in   = cmd_n;
            neg1_in  = neg1_n;
            neg2_in  = neg2_n;
            val1_in  = val1_n;
            val2_in  = val2_n;
            err_in   = err_n;
            done_in  = done_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mcld_pkg::PH_COLON;
         pos_ff   <= 3'd0;
         cmd_ff   <= 2'd0;
         neg1_ff  <= 1'b0;
         neg2_ff  <= 1'b0;
         val1_ff  <= 17'd0;
         val2_ff  <= 10'd0;
         err_ff   <= mcld_pkg::ERR_NONE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         cmd_ff   <= cmd_in;
         neg1_ff  <= neg1_in;
         neg2_ff  <= neg2_in;
         val1_ff  <= val1_in;
         val2_ff  <= val2_in;
         err_ff   <= err_in;
         done_ff  <= done_in;
      end
   end

endmodule

`default_nettype wire

[design/mcld_checker.sv]
// Port-level checks of the motor command line decoder and their binding.
`default_nettype none

`include "motor_command_line_decoder_macros.svh"

module mcld_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [mcld_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [mcld_pkg::RSP_USER_W-1:0] rsp_tuser
);

   // a stalled result stays
   `MCLD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped while stalled")

   // only defined kinds are sent
   `MCLD_ASSERT_IMPL(a_kind_range, rsp_tvalid, rsp_tuser <= mcld_pkg::KIND_ERROR, "bad cmd_kind")

   // error code only on error items
   `MCLD_ASSERT_IMPL(a_err_zero, rsp_tvalid && rsp_tuser != mcld_pkg::KIND_ERROR, rsp_tdata[40:39] == 2'd0, "error_code set on a command")

   // speed fields only on speed items
   `MCLD_ASSERT_IMPL(a_speed_zero, rsp_tvalid && rsp_tuser != mcld_pkg::KIND_SPEED, rsp_tdata[21:0] == 22'd0, "speed set on a non-speed item")

endmodule

bind motor_command_line_decoder mcld_checker u_mcld_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
